// ===== src/svi_pkg.sv =====
// Shared constants and types for the SVI volatility pipeline.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package svi_pkg;

  // Log2 mantissa and result formats.
  localparam int MANT_BITS = 30;
  localparam int LOG_BITS  = 28;

  // ln(2) with LOG_BITS fractional bits.
  localparam logic [LOG_BITS-1:0] LN2_Q28 = 28'd186065279;

  // Result status codes, in check order.
  typedef enum logic [2:0] {
    ST_OK,
    ST_STRIKE,
    ST_FORWARD,
    ST_EXPIRY,
    ST_SLOPE,
    ST_RHO,
    ST_SIGMA,
    ST_VARIANCE
  } status_t;

  // Configuration register indexes.
  localparam logic [2:0] REG_LEVEL_A   = 3'd0;
  localparam logic [2:0] REG_SLOPE_B   = 3'd1;
  localparam logic [2:0] REG_SKEW_RHO  = 3'd2;
  localparam logic [2:0] REG_SHIFT_M   = 3'd3;
  localparam logic [2:0] REG_SIGMA     = 3'd4;
  localparam logic [2:0] REG_FORWARD   = 3'd5;
  localparam logic [2:0] REG_EXPIRY    = 3'd6;

endpackage

// ===== src/svi_strike_if.sv =====
// Input channel carrying one strike word per handshake.
// No dependencies.
`timescale 1ns / 1ps

interface svi_strike_if #(
  parameter int WORD_BITS = 32
);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] strike_price;

  modport source (output valid, output strike_price, input ready);
  modport sink   (input valid, input strike_price, output ready);
endinterface

// ===== src/svi_result_if.sv =====
// Output channel carrying one volatility and status word per handshake.
// No dependencies.
`timescale 1ns / 1ps

interface svi_result_if #(
  parameter int WORD_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] volatility;
  logic [2:0]           status;

  modport source (output valid, output volatility, output status, input ready);
  modport sink   (input valid, input volatility, input status, output ready);
endinterface

// ===== src/svi_log_cell.sv =====
// One fractional bit of log2: square the mantissa and renormalize.
// Depends on svi_pkg for the mantissa and log formats.
`timescale 1ns / 1ps

module svi_log_cell import svi_pkg::*; #(
  parameter int PW = 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [MANT_BITS:0]  in_y,
  input  logic [LOG_BITS-1:0] in_frac,
  input  logic [PW-1:0]       in_pass,
  output logic                out_valid,
  output logic [MANT_BITS:0]  out_y,
  output logic [LOG_BITS-1:0] out_frac,
  output logic [PW-1:0]       out_pass
);

  logic [2*MANT_BITS+1:0] sq;
  logic [MANT_BITS+1:0]   y2;
  logic [MANT_BITS:0]     y_next;
  logic [LOG_BITS-1:0]    frac_next;

  // Square, drop the fraction, halve if the result reached two.
  always_comb begin
    sq        = in_y * in_y;
    y2        = sq[2*MANT_BITS+1:MANT_BITS];
    y_next    = y2[MANT_BITS+1] ? y2[MANT_BITS+1:1] : y2[MANT_BITS:0];
    frac_next = {in_frac[LOG_BITS-2:0], y2[MANT_BITS+1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_y    <= y_next;
      out_frac <= frac_next;
      out_pass <= in_pass;
    end
  end

endmodule

// ===== src/svi_sqrt_cell.sv =====
// One root bit of an integer square root (restoring digit recurrence).
// Depends on svi_pkg only for the shared import convention.
`timescale 1ns / 1ps

module svi_sqrt_cell import svi_pkg::*; #(
  parameter int RW = 32,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [RW+1:0]   in_rem,
  input  logic [RW-1:0]   in_root,
  input  logic [2*RW-1:0] in_rad,
  input  logic [PW-1:0]   in_pass,
  output logic            out_valid,
  output logic [RW+1:0]   out_rem,
  output logic [RW-1:0]   out_root,
  output logic [2*RW-1:0] out_rad,
  output logic [PW-1:0]   out_pass
);

  logic [RW+3:0]   pre;
  logic [RW+3:0]   trial;
  logic [RW+1:0]   rem_next;
  logic [RW-1:0]   root_next;
  logic [2*RW-1:0] rad_next;

  // Bring down two radicand bits and try the next root bit.
  always_comb begin
    pre   = {in_rem, in_rad[2*RW-1 -: 2]};
    trial = {2'b00, in_root, 2'b01};
    if (pre >= trial) begin
      rem_next  = RW'(pre - trial) | ((RW+2)'(pre - trial) & ~(RW+2)'({RW{1'b1}}));
      root_next = {in_root[RW-2:0], 1'b1};
    end else begin
      rem_next  = pre[RW+1:0];
      root_next = {in_root[RW-2:0], 1'b0};
    end
    rad_next = {in_rad[2*RW-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_root <= root_next;
      out_rad  <= rad_next;
      out_pass <= in_pass;
    end
  end

endmodule

// ===== src/svi_div_cell.sv =====
// One quotient bit of a restoring unsigned division.
// Depends on svi_pkg only for the shared import convention.
`timescale 1ns / 1ps

module svi_div_cell import svi_pkg::*; #(
  parameter int DW = 32,
  parameter int NW = 64,
  parameter int PW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [DW-1:0] divisor,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [NW-1:0] in_dvd,
  input  logic [NW-1:0] in_q,
  input  logic [PW-1:0] in_pass,
  output logic          out_valid,
  output logic [DW-1:0] out_rem,
  output logic [NW-1:0] out_dvd,
  output logic [NW-1:0] out_q,
  output logic [PW-1:0] out_pass
);

  logic [DW:0]   r2;
  logic [DW:0]   diff;
  logic [DW-1:0] rem_next;
  logic [NW-1:0] q_next;

  // Shift in the next dividend bit and subtract the divisor if it fits.
  always_comb begin
    r2   = {in_rem, in_dvd[NW-1]};
    diff = r2 - {1'b0, divisor};
    if (r2 >= {1'b0, divisor}) begin
      rem_next = diff[DW-1:0];
      q_next   = {in_q[NW-2:0], 1'b1};
    end else begin
      rem_next = r2[DW-1:0];
      q_next   = {in_q[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_rem  <= rem_next;
      out_dvd  <= {in_dvd[NW-2:0], 1'b0};
      out_q    <= q_next;
      out_pass <= in_pass;
    end
  end

endmodule

// ===== src/svi_implied_volatility_top.sv =====
// Top level of the SVI smile slice: checks, log-moneyness, variance and volatility.
// Depends on svi_pkg, svi_strike_if, svi_result_if and the three cell modules.
// Throughput: one strike word per cycle; the whole pipeline holds while a result waits.
// The pipeline depth is set by the cell chains: log2 squaring, two square roots and the divider.
// Reset clears every valid flag and loads the register defaults; no clearing pass.
`timescale 1ns / 1ps

module svi_implied_volatility_top import svi_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int WORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [2:0]           cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data,
  svi_strike_if.sink           strike,
  svi_result_if.source         result
);

  localparam int W    = WORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int EW   = $clog2(W);
  localparam int LGW  = EW + LOG_BITS;
  localparam int PAW  = LGW + LOG_BITS;
  localparam int KS   = 2 * LOG_BITS - F;
  localparam int SQW  = 2 * W;
  localparam int RPW  = 2 * W + 1;
  localparam int RDW  = W + 3;
  localparam int IW   = W + 4;
  localparam int BPW  = 2 * W + 3;
  localparam int WW   = 2 * W + 5 - F;
  localparam int CW   = 3 * W + 6;
  localparam int SH   = 2 * W - 2 * F;
  localparam int LPW  = 3 + EW;
  localparam int S1PW = 3 + RDW;

  localparam logic [PAW:0]    K_HALF  = (PAW+1)'(1) << (KS - 1);
  localparam logic [RPW-1:0]  RP_HALF = RPW'(1) << (F - 1);
  localparam logic [BPW:0]    BP_HALF = (BPW+1)'(1) << (F - 1);
  localparam logic signed [W:0] ONE   = (W+1)'(1) << F;

  // Configuration registers.
  logic signed [W-1:0] level_a, slope_b, skew_rho, shift_m;
  logic signed [W-1:0] curvature_sigma, forward_price, expiry_years;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_a         <= '0;
      slope_b         <= '0;
      skew_rho        <= '0;
      shift_m         <= '0;
      curvature_sigma <= W'(1) << F;
      forward_price   <= W'(1) << F;
      expiry_years    <= W'(1) << F;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEVEL_A:  level_a         <= cfg_data;
        REG_SLOPE_B:  slope_b         <= cfg_data;
        REG_SKEW_RHO: skew_rho        <= cfg_data;
        REG_SHIFT_M:  shift_m         <= cfg_data;
        REG_SIGMA:    curvature_sigma <= cfg_data;
        REG_FORWARD:  forward_price   <= cfg_data;
        REG_EXPIRY:   expiry_years    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless a finished result is held.
  logic out_valid;
  logic adv;
  assign adv          = !out_valid || result.ready;
  assign strike.ready = adv;

  // Position of the leading one of a positive word.
  function automatic logic [EW-1:0] lead_one(input logic [W-1:0] v);
    logic [EW-1:0] e;
    e = '0;
    for (int i = 0; i < W; i++) begin
      if (v[i]) e = EW'(i);
    end
    return e;
  endfunction

  // Mantissa normalized to one integer bit and MANT_BITS fraction bits.
  function automatic logic [MANT_BITS:0] norm(input logic [W-1:0] v,
                                              input logic [EW-1:0] e);
    logic [W+MANT_BITS:0] wide;
    wide = (W+MANT_BITS+1)'(v);
    if (e > MANT_BITS) wide = wide >> (e - MANT_BITS);
    else               wide = wide << (MANT_BITS - e);
    return wide[MANT_BITS:0];
  endfunction

  // Input stage: parameter checks in status order, mantissa normalization.
  status_t            in_status;
  logic [EW-1:0]      in_es, in_ef;
  logic signed [W:0]  rho_x;

  always_comb begin
    rho_x = {skew_rho[W-1], skew_rho};
    in_es = lead_one(strike.strike_price);
    in_ef = lead_one(forward_price);
    priority if (strike.strike_price <= 0)     in_status = ST_STRIKE;
    else if (forward_price <= 0)               in_status = ST_FORWARD;
    else if (expiry_years < 0)                 in_status = ST_EXPIRY;
    else if (slope_b < 0)                      in_status = ST_SLOPE;
    else if (rho_x >= ONE || rho_x <= -ONE)    in_status = ST_RHO;
    else if (curvature_sigma <= 0)             in_status = ST_SIGMA;
    else                                       in_status = ST_OK;
  end

  logic                s0_valid;
  status_t             s0_status;
  logic [EW-1:0]       s0_es, s0_ef;
  logic [MANT_BITS:0]  s0_ys, s0_yf;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_status <= in_status;
      s0_es     <= in_es;
      s0_ef     <= in_ef;
      s0_ys     <= norm(strike.strike_price, in_es);
      s0_yf     <= norm(forward_price, in_ef);
    end
  end

  // Log2 chains for strike and forward, one fraction bit per cell.
  logic                ls_v [0:LOG_BITS];
  logic [MANT_BITS:0]  ls_y [0:LOG_BITS];
  logic [LOG_BITS-1:0] ls_f [0:LOG_BITS];
  logic [LPW-1:0]      ls_p [0:LOG_BITS];
  logic                lf_v [0:LOG_BITS];
  logic [MANT_BITS:0]  lf_y [0:LOG_BITS];
  logic [LOG_BITS-1:0] lf_f [0:LOG_BITS];
  logic [EW-1:0]       lf_p [0:LOG_BITS];

  assign ls_v[0] = s0_valid;
  assign ls_y[0] = s0_ys;
  assign ls_f[0] = '0;
  assign ls_p[0] = {s0_status, s0_es};
  assign lf_v[0] = s0_valid;
  assign lf_y[0] = s0_yf;
  assign lf_f[0] = '0;
  assign lf_p[0] = s0_ef;

  for (genvar i = 0; i < LOG_BITS; i++) begin : g_log
    svi_log_cell #(.PW(LPW)) u_ls (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(ls_v[i]), .in_y(ls_y[i]), .in_frac(ls_f[i]), .in_pass(ls_p[i]),
      .out_valid(ls_v[i+1]), .out_y(ls_y[i+1]), .out_frac(ls_f[i+1]),
      .out_pass(ls_p[i+1])
    );
    svi_log_cell #(.PW(EW)) u_lf (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(lf_v[i]), .in_y(lf_y[i]), .in_frac(lf_f[i]), .in_pass(lf_p[i]),
      .out_valid(lf_v[i+1]), .out_y(lf_y[i+1]), .out_frac(lf_f[i+1]),
      .out_pass(lf_p[i+1])
    );
  end

  // Stage A: log2 difference times ln2.
  logic [LGW-1:0]      lg_s, lg_f, dl_mag;
  logic signed [LGW:0] dl;

  always_comb begin
    lg_s   = {ls_p[LOG_BITS][EW-1:0], ls_f[LOG_BITS]};
    lg_f   = {lf_p[LOG_BITS], lf_f[LOG_BITS]};
    dl     = $signed({1'b0, lg_s}) - $signed({1'b0, lg_f});
    dl_mag = dl[LGW] ? LGW'(-dl) : dl[LGW-1:0];
  end

  logic            sa_valid;
  status_t         sa_status;
  logic            sa_neg;
  logic [PAW-1:0]  sa_prod;

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_status <= status_t'(ls_p[LOG_BITS][LPW-1:EW]);
      sa_neg    <= dl[LGW];
      sa_prod   <= dl_mag * LN2_Q28;
    end
  end

  // Stage B: round to k, subtract m, take the magnitude.
  logic [PAW:0]          k_round;
  logic signed [W+1:0]   k_abs, k_val, d_val;
  logic [W:0]            d_mag;

  always_comb begin
    k_round = ((PAW+1)'(sa_prod) + K_HALF) >> KS;
    k_abs   = (W+2)'(k_round);
    k_val   = sa_neg ? -k_abs : k_abs;
    d_val   = k_val - $signed({{2{shift_m[W-1]}}, shift_m});
    d_mag   = d_val[W+1] ? (W+1)'(-d_val) : d_val[W:0];
  end

  logic        sb_valid;
  status_t     sb_status;
  logic        sb_dneg;
  logic [W:0]  sb_dm;

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_status <= sa_status;
      sb_dneg   <= d_val[W+1];
      sb_dm     <= d_mag;
    end
  end

  // Stage C: squares and the rho product.
  logic [W-1:0] rho_abs;
  assign rho_abs = skew_rho[W-1] ? W'(-skew_rho) : W'(skew_rho);

  logic             sc_valid;
  status_t          sc_status;
  logic             sc_rneg;
  logic [2*W+1:0]   sc_sqd;
  logic [SQW-1:0]   sc_sqs;
  logic [RPW-1:0]   sc_rp;

  always_ff @(posedge clk) begin
    if (adv) begin
      sc_status <= sb_status;
      sc_rneg   <= skew_rho[W-1] != sb_dneg;
      sc_sqd    <= sb_dm * sb_dm;
      sc_sqs    <= W'(curvature_sigma) * W'(curvature_sigma);
      sc_rp     <= rho_abs * sb_dm;
    end
  end

  // Stage D: radicand sum and rounded rho term.
  logic [RPW-1:0]        rd_round;
  logic [W+1:0]          rd_mag;
  logic signed [RDW-1:0] rd_val;

  always_comb begin
    rd_round = (sc_rp + RP_HALF) >> F;
    rd_mag   = (W+2)'(rd_round);
    rd_val   = sc_rneg ? -$signed({1'b0, rd_mag}) : $signed({1'b0, rd_mag});
  end

  logic           sd_valid;
  status_t        sd_status;
  logic [SQW-1:0] sd_sum;
  logic [RDW-1:0] sd_rd;

  always_ff @(posedge clk) begin
    if (adv) begin
      sd_status <= sc_status;
      sd_sum    <= sc_sqd[SQW-1:0] + sc_sqs;
      sd_rd     <= rd_val;
    end
  end

  // Square root of (k-m)^2 + sigma^2, one root bit per cell.
  logic            q1_v [0:W];
  logic [W+1:0]    q1_r [0:W];
  logic [W-1:0]    q1_t [0:W];
  logic [SQW-1:0]  q1_n [0:W];
  logic [S1PW-1:0] q1_p [0:W];

  assign q1_v[0] = sd_valid;
  assign q1_r[0] = '0;
  assign q1_t[0] = '0;
  assign q1_n[0] = sd_sum;
  assign q1_p[0] = {sd_status, sd_rd};

  for (genvar i = 0; i < W; i++) begin : g_sqrt1
    svi_sqrt_cell #(.RW(W), .PW(S1PW)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(q1_v[i]), .in_rem(q1_r[i]), .in_root(q1_t[i]), .in_rad(q1_n[i]),
      .in_pass(q1_p[i]),
      .out_valid(q1_v[i+1]), .out_rem(q1_r[i+1]), .out_root(q1_t[i+1]),
      .out_rad(q1_n[i+1]), .out_pass(q1_p[i+1])
    );
  end

  // Stage E: inner sum clamped at zero, times b.
  logic signed [IW-1:0] inner;
  logic [W+2:0]         inner_u;
  logic [RDW-1:0]       e_rd;

  always_comb begin
    e_rd    = q1_p[W][RDW-1:0];
    inner   = $signed({e_rd[RDW-1], e_rd}) + $signed({4'b0000, q1_t[W]});
    inner_u = inner[IW-1] ? '0 : inner[W+2:0];
  end

  logic           se_valid;
  status_t        se_status;
  logic [BPW-1:0] se_bp;

  always_ff @(posedge clk) begin
    if (adv) begin
      se_status <= status_t'(q1_p[W][S1PW-1:RDW]);
      se_bp     <= W'(slope_b) * inner_u;
    end
  end

  // Stage F: total variance w = a + round(b * inner).
  logic [BPW:0] b_round;
  assign b_round = ((BPW+1)'(se_bp) + BP_HALF) >> F;

  logic                 sf_valid;
  status_t              sf_status;
  logic signed [WW-1:0] sf_w;

  always_ff @(posedge clk) begin
    if (adv) begin
      sf_status <= se_status;
      sf_w      <= $signed({{(WW-W){level_a[W-1]}}, level_a})
                   + $signed({1'b0, b_round[WW-2:0]});
    end
  end

  // Stage G: variance and expiry checks, saturation test, divider setup.
  logic [CW-1:0] w_u, t_shift;
  logic [W-1:0]  t_u;
  status_t       g_status;

  always_comb begin
    t_u     = W'(expiry_years);
    w_u     = CW'(sf_w);
    t_shift = CW'(t_u) << SH;
    if (sf_status == ST_OK && (t_u == '0 || sf_w[WW-1])) g_status = ST_VARIANCE;
    else                                                   g_status = sf_status;
  end

  logic           sg_valid;
  status_t        sg_status;
  logic           sg_sat;
  logic [W-1:0]   sg_rem;
  logic [SQW-1:0] sg_dvd;

  always_ff @(posedge clk) begin
    if (adv) begin
      sg_status <= g_status;
      sg_sat    <= w_u >= t_shift;
      sg_rem    <= W'(w_u >> SH);
      sg_dvd    <= SQW'(w_u << (2 * F));
    end
  end

  // Divider chain: w * 2^(2F) / T, one quotient bit per cell.
  logic           dv_v [0:SQW];
  logic [W-1:0]   dv_r [0:SQW];
  logic [SQW-1:0] dv_n [0:SQW];
  logic [SQW-1:0] dv_q [0:SQW];
  logic [3:0]     dv_p [0:SQW];

  assign dv_v[0] = sg_valid;
  assign dv_r[0] = sg_rem;
  assign dv_n[0] = sg_dvd;
  assign dv_q[0] = '0;
  assign dv_p[0] = {sg_status, sg_sat};

  for (genvar i = 0; i < SQW; i++) begin : g_div
    svi_div_cell #(.DW(W), .NW(SQW), .PW(4)) u_cell (
      .clk(clk), .rst(rst), .en(adv), .divisor(t_u),
      .in_valid(dv_v[i]), .in_rem(dv_r[i]), .in_dvd(dv_n[i]), .in_q(dv_q[i]),
      .in_pass(dv_p[i]),
      .out_valid(dv_v[i+1]), .out_rem(dv_r[i+1]), .out_dvd(dv_n[i+1]),
      .out_q(dv_q[i+1]), .out_pass(dv_p[i+1])
    );
  end

  // Square root of the quotient gives the volatility.
  logic           q2_v [0:W];
  logic [W+1:0]   q2_r [0:W];
  logic [W-1:0]   q2_t [0:W];
  logic [SQW-1:0] q2_n [0:W];
  logic [3:0]     q2_p [0:W];

  assign q2_v[0] = dv_v[SQW];
  assign q2_r[0] = '0;
  assign q2_t[0] = '0;
  assign q2_n[0] = dv_q[SQW];
  assign q2_p[0] = dv_p[SQW];

  for (genvar i = 0; i < W; i++) begin : g_sqrt2
    svi_sqrt_cell #(.RW(W), .PW(4)) u_cell (
      .clk(clk), .rst(rst), .en(adv),
      .in_valid(q2_v[i]), .in_rem(q2_r[i]), .in_root(q2_t[i]), .in_rad(q2_n[i]),
      .in_pass(q2_p[i]),
      .out_valid(q2_v[i+1]), .out_rem(q2_r[i+1]), .out_root(q2_t[i+1]),
      .out_rad(q2_n[i+1]), .out_pass(q2_p[i+1])
    );
  end

  // Output register: zero on error, all ones on saturation.
  status_t      o_status;
  logic [W-1:0] out_vol;
  status_t      out_status;

  assign o_status = status_t'(q2_p[W][3:1]);

  always_ff @(posedge clk) begin
    if (adv) begin
      out_status <= o_status;
      if (o_status != ST_OK) out_vol <= '0;
      else if (q2_p[W][0])   out_vol <= '1;
      else                   out_vol <= q2_t[W];
    end
  end

  // Valid flags of the top-level stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid  <= 1'b0;
      sa_valid  <= 1'b0;
      sb_valid  <= 1'b0;
      sc_valid  <= 1'b0;
      sd_valid  <= 1'b0;
      se_valid  <= 1'b0;
      sf_valid  <= 1'b0;
      sg_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s0_valid  <= strike.valid;
      sa_valid  <= ls_v[LOG_BITS] && lf_v[LOG_BITS];
      sb_valid  <= sa_valid;
      sc_valid  <= sb_valid;
      sd_valid  <= sc_valid;
      se_valid  <= q1_v[W];
      sf_valid  <= se_valid;
      sg_valid  <= sf_valid;
      out_valid <= q2_v[W];
    end
  end

  assign result.valid      = out_valid;
  assign result.volatility = out_vol;
  assign result.status     = out_status;

endmodule

// ===== tb/tb_svi_implied_volatility_top.sv =====
// Self-checking testbench for svi_implied_volatility_top: directed strikes and config, then
// random smile slices, each result checked against its table value or an in-bench fixed-point predictor.
// Depends on svi_pkg, svi_strike_if, svi_result_if and the RTL top level.
`timescale 1ns / 1ps

module tb_svi_implied_volatility_top;
  import svi_pkg::*;

  localparam int FRAC_BITS  = 16;
  localparam int WORD_BITS  = 32;
  localparam int PIPE_DEPTH = 37 + 4 * WORD_BITS;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_LEN   = 400;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 122;
  localparam logic [31:0] ONE = 32'h0001_0000;

  // One expected result word.
  typedef struct {
    logic [31:0] vol;
    status_t     st;
  } smile_result_t;

  // One row of the directed table: a register write or a strike.
  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [31:0] value;
    bit          known;
    logic [31:0] vol;
    status_t     st;
  } smile_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  svi_strike_if #(.WORD_BITS(WORD_BITS)) strike_ch ();
  svi_result_if #(.WORD_BITS(WORD_BITS)) result_ch ();

  svi_implied_volatility_top #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .strike    (strike_ch),
    .result    (result_ch)
  );

  logic [31:0]   slice_regs [7];
  smile_result_t pending_vols[$];
  smile_row_t    directed_rows[$];
  int            mismatch_count = 0;
  bit            hold_request = 0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Integer square root, floor, bit by bit.
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] probe;
    res = 0;
    probe = 64'h1 << 62;
    while (probe > n) probe >>= 2;
    while (probe != 0) begin
      if (n >= res + probe) begin
        n = n - (res + probe);
        res = (res >> 1) + probe;
      end else begin
        res >>= 1;
      end
      probe >>= 2;
    end
    return res;
  endfunction

  // log2 of a positive integer with LOG_BITS fractional bits, by repeated squaring.
  function automatic longint log2_fix(logic [63:0] raw);
    int          e;
    logic [63:0] y;
    logic [63:0] frac;
    logic [63:0] fbit;
    e = 63;
    while (e > 0 && raw[e] == 1'b0) e--;
    if (e > MANT_BITS) y = raw >> (e - MANT_BITS);
    else y = raw << (MANT_BITS - e);
    frac = 0;
    for (fbit = 64'h1 << (LOG_BITS - 1); fbit != 0; fbit >>= 1) begin
      y = (y * y) >> MANT_BITS;
      if (y >= (64'd2 << MANT_BITS)) begin
        y >>= 1;
        frac |= fbit;
      end
    end
    return longint'(e) * (64'sd1 << LOG_BITS) + longint'(frac);
  endfunction

  // Predict volatility and status of one strike under the current slice registers.
  function automatic smile_result_t predict_smile(logic [31:0] strike_raw);
    smile_result_t res;
    longint      s, a, b, rho, m, sg, fwd, t, dl, k, d, rd, inner, w;
    logic [63:0] mdl, km, dm, r, rm, bw, v;
    logic [127:0] quo;
    s   = longint'($signed(strike_raw));
    a   = longint'($signed(slice_regs[REG_LEVEL_A]));
    b   = longint'($signed(slice_regs[REG_SLOPE_B]));
    rho = longint'($signed(slice_regs[REG_SKEW_RHO]));
    m   = longint'($signed(slice_regs[REG_SHIFT_M]));
    sg  = longint'($signed(slice_regs[REG_SIGMA]));
    fwd = longint'($signed(slice_regs[REG_FORWARD]));
    t   = longint'($signed(slice_regs[REG_EXPIRY]));
    res.vol = 32'd0;
    res.st  = ST_OK;
    if (s <= 0) res.st = ST_STRIKE;
    else if (fwd <= 0) res.st = ST_FORWARD;
    else if (t < 0) res.st = ST_EXPIRY;
    else if (b < 0) res.st = ST_SLOPE;
    else if (rho >= 65536 || rho <= -65536) res.st = ST_RHO;
    else if (sg <= 0) res.st = ST_SIGMA;
    if (res.st == ST_OK) begin
      // Log-moneyness, rounded ties away from zero.
      dl  = log2_fix(s) - log2_fix(fwd);
      mdl = (dl < 0) ? -dl : dl;
      km  = (mdl * 64'(LN2_Q28) + (64'h1 << (2 * LOG_BITS - FRAC_BITS - 1)))
            >> (2 * LOG_BITS - FRAC_BITS);
      k   = (dl < 0) ? -longint'(km) : longint'(km);
      d   = k - m;
      dm  = (d < 0) ? -d : d;
      r   = floor_sqrt(dm * dm + 64'(sg) * 64'(sg));
      rm  = ((rho < 0 ? -rho : rho) * dm + (64'h1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      rd  = ((rho < 0) != (d < 0)) ? -longint'(rm) : longint'(rm);
      inner = rd + longint'(r);
      if (inner < 0) inner = 0;
      bw = (64'(b) * 64'(inner) + (64'h1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      w  = a + longint'(bw);
      if (t == 0 || w < 0) begin
        res.st = ST_VARIANCE;
      end else begin
        // Exact w * 2^(2F) / T, saturating when the quotient leaves 64 bits.
        quo = (128'(w) << (2 * FRAC_BITS)) / 128'(t);
        if (quo[127:64] != 0) begin
          res.vol = '1;
        end else begin
          v = floor_sqrt(quo[63:0]);
          res.vol = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        end
      end
    end
    return res;
  endfunction

  // Register write, with cfg_write low again before the task returns.
  task automatic write_slice_reg(logic [2:0] idx, logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    if (idx < 7) slice_regs[idx] = value;
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  // Pause the strike stream until every expected result has come back.
  task automatic drain_results();
    strike_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_vols.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Offer one strike word and hold it until accepted.
  task automatic send_strike(logic [31:0] value, bit known, smile_result_t want);
    strike_ch.valid        <= 1'b1;
    strike_ch.strike_price <= value;
    do @(posedge clk); while (!strike_ch.ready);
    pending_vols.push_back(known ? want : predict_smile(value));
  endtask

  task automatic add_row(bit is_cfg, logic [2:0] idx, logic [31:0] value,
                         bit known = 0, logic [31:0] vol = 0, status_t st = ST_OK);
    smile_row_t row;
    row.is_cfg = is_cfg;
    row.idx    = idx;
    row.value  = value;
    row.known  = known;
    row.vol    = vol;
    row.st     = st;
    directed_rows.push_back(row);
  endtask

  // Slice register value: mostly a well-formed smile, sometimes an extreme or raw noise.
  function automatic logic [31:0] pick_reg(logic [2:0] idx);
    int sel;
    sel = $urandom_range(0, 15);
    if (sel == 0) return $urandom;
    if (sel == 1) begin
      case ($urandom_range(0, 3))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'h0000_0001;
      endcase
    end
    case (idx)
      REG_LEVEL_A:  return $urandom_range(0, 32'h0002_0000) - 32'h4000;
      REG_SLOPE_B:  return $urandom_range(0, 32'h0002_0000);
      REG_SKEW_RHO: return $urandom_range(0, 32'h0001_FFFE) - 32'h0000_FFFF;
      REG_SHIFT_M:  return $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
      REG_SIGMA:    return $urandom_range(1, 32'h0002_0000);
      REG_FORWARD:  return $urandom >> $urandom_range(1, 24) | 32'h1;
      default:      return $urandom_range(1, 32'h0008_0000);
    endcase
  endfunction

  // Strike value: mostly positive across all magnitudes, some near the forward, some noise.
  function automatic logic [31:0] pick_strike();
    int          sel;
    logic [31:0] v;
    sel = $urandom_range(0, 19);
    if (sel < 2) return $urandom;
    if (sel < 3) return -$urandom_range(0, 1000);
    if (sel < 7) begin
      v = slice_regs[REG_FORWARD] + $urandom_range(0, 2000) - 1000;
      return ($signed(v) > 0) ? v : 32'h1;
    end
    v = $urandom >> $urandom_range(1, 31);
    return (v == 0) ? 32'h1 : v;
  endfunction

  // Stimulus: reset, directed table, then random slices in bursts.
  initial begin
    smile_result_t want;
    smile_row_t    row;
    int            burst_left;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_LEVEL_A;
    cfg_data  = '0;
    strike_ch.valid = 1'b0;
    strike_ch.strike_price = '0;
    slice_regs[REG_LEVEL_A]  = 0;
    slice_regs[REG_SLOPE_B]  = 0;
    slice_regs[REG_SKEW_RHO] = 0;
    slice_regs[REG_SHIFT_M]  = 0;
    slice_regs[REG_SIGMA]    = ONE;
    slice_regs[REG_FORWARD]  = ONE;
    slice_regs[REG_EXPIRY]   = ONE;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults after reset, strike extremes, and each error status.
    add_row(0, 0, ONE, 1, 32'd0, ST_OK);
    add_row(0, 0, 32'h0000_0000, 1, 32'd0, ST_STRIKE);
    add_row(0, 0, 32'h8000_0000, 1, 32'd0, ST_STRIKE);
    add_row(0, 0, 32'h7FFF_FFFF);
    add_row(0, 0, 32'h0000_0001);
    add_row(1, REG_SLOPE_B, 32'h0000_8000);
    add_row(0, 0, 32'h0002_0000);
    add_row(0, 0, 32'h0000_8000);
    add_row(1, REG_SKEW_RHO, 32'hFFFF_8000);
    add_row(0, 0, 32'h0003_0000);
    add_row(1, REG_FORWARD, 32'h0000_0000);
    add_row(0, 0, ONE, 1, 32'd0, ST_FORWARD);
    add_row(0, 0, 32'h0000_0000, 1, 32'd0, ST_STRIKE);
    add_row(1, REG_FORWARD, ONE);
    add_row(1, REG_EXPIRY, 32'hFFFF_FFFF);
    add_row(0, 0, ONE, 1, 32'd0, ST_EXPIRY);
    add_row(1, REG_EXPIRY, 32'h0000_0000);
    add_row(0, 0, ONE, 1, 32'd0, ST_VARIANCE);
    add_row(1, REG_EXPIRY, ONE);
    add_row(1, REG_SLOPE_B, 32'hFFFF_FFFF);
    add_row(0, 0, ONE, 1, 32'd0, ST_SLOPE);
    add_row(1, REG_SLOPE_B, 32'h0000_8000);
    add_row(1, REG_SKEW_RHO, ONE);
    add_row(0, 0, ONE, 1, 32'd0, ST_RHO);
    add_row(1, REG_SKEW_RHO, 32'hFFFF_0000);
    add_row(0, 0, ONE, 1, 32'd0, ST_RHO);
    add_row(1, REG_SKEW_RHO, 32'h0000_0000);
    add_row(1, REG_SIGMA, 32'h0000_0000);
    add_row(0, 0, ONE, 1, 32'd0, ST_SIGMA);
    add_row(1, REG_SIGMA, ONE);
    add_row(1, REG_LEVEL_A, 32'h8000_0000);
    add_row(0, 0, ONE, 1, 32'd0, ST_VARIANCE);
    // Overflow: huge variance over the smallest expiry saturates.
    add_row(1, REG_LEVEL_A, 32'h7FFF_FFFF);
    add_row(1, REG_SLOPE_B, 32'h7FFF_FFFF);
    add_row(1, REG_SIGMA, 32'h0002_0000);
    add_row(1, REG_EXPIRY, 32'h0000_0001);
    add_row(0, 0, ONE, 1, 32'hFFFF_FFFF, ST_OK);
    // A write beyond the last register is ignored.
    add_row(1, 3'd7, 32'h1234_5678);
    add_row(0, 0, 32'h0000_4000);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.is_cfg) begin
        drain_results();
        write_slice_reg(row.idx, row.value);
      end else begin
        want.vol = row.vol;
        want.st  = row.st;
        send_strike(row.value, row.known, want);
      end
    end

    // Random slices; the first one also holds the receiver off for a long stretch.
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      for (int r = 0; r < 7; r++) write_slice_reg(r[2:0], pick_reg(r[2:0]));
      if (p == 0) hold_request = 1;
      burst_left = $urandom_range(1, 30);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) begin
            strike_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
          end
          burst_left = $urandom_range(1, 30);
        end
        send_strike(pick_strike(), 0, want);
        burst_left--;
      end
    end

    drain_results();
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Receiver: check each accepted word, then pick ready from the current stall pattern.
  initial begin
    smile_result_t want;
    int stall_mode;
    int mode_left;
    int hold_left;
    bit hold_done;
    stall_mode = 0;
    mode_left  = 0;
    hold_left  = 0;
    hold_done  = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_ch.valid && result_ch.ready) begin
        if (pending_vols.size() == 0) begin
          flag_mismatch("unexpected result", result_ch.volatility, 32'd0);
        end else begin
          want = pending_vols.pop_front();
          if (result_ch.volatility !== want.vol)
            flag_mismatch("volatility", result_ch.volatility, want.vol);
          if (result_ch.status !== want.st)
            flag_mismatch("status", 32'(result_ch.status), 32'(want.st));
        end
      end
      if (hold_request && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_LEN;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left  = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        case (stall_mode)
          0: result_ch.ready <= 1'b1;
          1: result_ch.ready <= ($urandom_range(0, 3) != 0);
          default: result_ch.ready <= (mode_left % 5 != 2);
        endcase
      end
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((strike_ch.valid && strike_ch.ready) || (result_ch.valid && result_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timeout: no handshake in %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

endmodule
